// File: hw/rtl/point_cloud_background_subtract_unit_macros.svh
// Assertion macros shared by the background subtraction RTL.
`ifndef POINT_CLOUD_BACKGROUND_SUBTRACT_UNIT_MACROS_SVH
`define POINT_CLOUD_BACKGROUND_SUBTRACT_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds at every clock edge outside reset
`define PCBS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

// Check that a consequent holds in the same cycle as its antecedent
`define PCBS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

// Check that a consequent holds in the cycle after its antecedent
`define PCBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define PCBS_ASSERT_ALWAYS(lbl, expr)
`define PCBS_ASSERT_IMPL(lbl, ante, cons)
`define PCBS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/pcbs_pkg.sv
// Shared types and constants of the point cloud background subtraction unit.
package pcbs_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

  // Register and field widths
  localparam int THR_W    = 16;
  localparam int DIM_W    = 13;
  localparam int PROD_W   = 2 * DIM_W;
  localparam int THR_SQ_W = 2 * THR_W;
  localparam int COLOR_W  = 24;

  // Register reset values
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd600;
  localparam logic [DIM_W-1:0] WIDTH_RESET     = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET    = 13'd360;

  // Result kinds carried on tuser
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_EOF   = 1'b1;

  // Decision queue between front and back
  localparam int QUEUE_DEPTH = 8;
  localparam int Q_PTR_W     = 3;
  localparam int Q_CNT_W     = 4;

  // Per-item decision passed through the queue
  typedef struct packed {
    logic fg;   // point is foreground and is sent on
    logic eof;  // point closes a compared frame
  } pcbs_ctrl_t;

endpackage

// File: hw/rtl/point_cloud_background_subtract_unit.sv
// Top level of the point cloud background subtraction unit.
// The unit takes one point per cycle while the decision queue has room; each point needs a
// single read of the background store, which has one read and one write port. The first
// whole frame after reset is written into the store and gives no output; every later point
// is compared with the stored point at the same scan position and comes out as a point beat
// when both are valid and its squared distance exceeds the squared threshold; the last point
// of each frame adds an end-of-frame beat. A point passes stage one, stage two, the queue and
// the output register into its beats; the queue decouples input from output, so input
// stalls only when the queue plus up to two points in the pipeline ahead would exceed
// eight entries. The store has no clearing pass and needs no wait after reset. Frame size
// is width times height, zero counted as one and clamped to the store depth. The user must
// write configuration only while no point is in flight; the unit does not enforce it.
module point_cloud_background_subtract_unit #(
  parameter int STORE_POINTS = 262144,
  parameter int COORD_BITS   = 18,
  localparam int TDATA_W     = ((3 * COORD_BITS + pcbs_pkg::COLOR_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcbs_pkg::CFG_DATA_W-1:0] cfg_data,
  // Point stream in
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [TDATA_W-1:0]              s_tdata,   // point_x, point_y, point_z, point_color
  input  logic                            s_tuser,   // point_valid
  // Result stream out
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [TDATA_W-1:0]              m_tdata,   // out_x, out_y, out_z, out_color
  output logic                            m_tuser,   // item_kind
  output logic                            m_tlast    // last_of_run
);
  import pcbs_pkg::*;

  localparam int PAY_W = 3 * COORD_BITS + COLOR_W;

  logic signed [COORD_BITS-1:0] in_x, in_y, in_z;
  logic [COLOR_W-1:0]           in_color;
  logic                         push;
  pcbs_ctrl_t                   push_ctrl;
  logic [PAY_W-1:0]             push_data;
  logic                         q_valid;
  pcbs_ctrl_t                   q_ctrl;
  logic [PAY_W-1:0]             q_data;
  logic                         q_pop;
  logic [Q_CNT_W-1:0]           q_count;

  // Unpack the input beat
  assign in_x     = s_tdata[COORD_BITS-1:0];
  assign in_y     = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_z     = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign in_color = s_tdata[3*COORD_BITS+COLOR_W-1:3*COORD_BITS];

  pcbs_front #(
    .STORE_POINTS (STORE_POINTS),
    .COORD_BITS   (COORD_BITS),
    .PAY_W        (PAY_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .in_color  (in_color),
    .in_pvalid (s_tuser),
    .q_count   (q_count),
    .push      (push),
    .push_ctrl (push_ctrl),
    .push_data (push_data)
  );

  pcbs_queue #(
    .WIDTH (PAY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_ctrl   (push_ctrl),
    .in_data   (push_data),
    .pop       (q_pop),
    .out_valid (q_valid),
    .out_ctrl  (q_ctrl),
    .out_data  (q_data),
    .count     (q_count)
  );

  pcbs_back #(
    .PAY_W   (PAY_W),
    .TDATA_W (TDATA_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ctrl   (q_ctrl),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: hw/rtl/pcbs_front.sv
// Front end: configuration registers, scan tracking, background store and distance test.
module pcbs_front #(
  parameter int STORE_POINTS = 262144,
  parameter int COORD_BITS   = 18,
  parameter int PAY_W        = 3 * 18 + 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcbs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_BITS-1:0]    in_x,
  input  logic signed [COORD_BITS-1:0]    in_y,
  input  logic signed [COORD_BITS-1:0]    in_z,
  input  logic [pcbs_pkg::COLOR_W-1:0]    in_color,
  input  logic                            in_pvalid,
  input  logic [pcbs_pkg::Q_CNT_W-1:0]    q_count,
  output logic                            push,
  output pcbs_pkg::pcbs_ctrl_t            push_ctrl,
  output logic [PAY_W-1:0]                push_data
);
  import pcbs_pkg::*;

  localparam int PB    = $clog2(STORE_POINTS);
  localparam int PN_W  = PB + 1;
  localparam int MEM_W = 3 * COORD_BITS + 1;
  localparam int D_W   = COORD_BITS + 1;
  localparam int SQ_W  = 2 * COORD_BITS + 1;
  localparam int SUM_W = 2 * COORD_BITS + 3;
  localparam int CMP_W = (SUM_W > THR_SQ_W) ? SUM_W : THR_SQ_W;
  localparam int RESET_PROD = 640 * 360;
  localparam logic [PN_W-1:0] RESET_POINTS =
    PN_W'((RESET_PROD > STORE_POINTS) ? STORE_POINTS : RESET_PROD);
  localparam logic [THR_SQ_W-1:0] RESET_THR_SQ = THR_SQ_W'(600 * 600);
  localparam logic [PROD_W-1:0] STORE_N = PROD_W'(STORE_POINTS);

  // Configuration registers
  logic [THR_W-1:0]    thr, thr_next;
  logic [DIM_W-1:0]    wid, wid_next;
  logic [DIM_W-1:0]    hei, hei_next;
  logic [THR_SQ_W-1:0] thr_sq;
  logic [PN_W-1:0]     points;
  logic [PROD_W-1:0]   prod;
  logic [PN_W-1:0]     points_next;

  // Scan tracking
  logic          captured;
  logic [PB-1:0] pos;
  logic [PN_W-1:0] pos_inc;
  logic          frame_end;
  logic          accept;
  logic [1:0]    inflight;

  // Background store
  logic [MEM_W-1:0] mem [0:STORE_POINTS-1];
  logic [MEM_W-1:0] rd_data;

  // Stage one: point with its background read
  logic                         s1_valid;
  logic                         s1_cmp;
  logic                         s1_eof;
  logic signed [COORD_BITS-1:0] s1_x, s1_y, s1_z;
  logic [COLOR_W-1:0]           s1_color;
  logic                         s1_pvalid;
  logic signed [COORD_BITS-1:0] bg_x, bg_y, bg_z;
  logic                         bg_pvalid;
  logic signed [D_W-1:0]        dx, dy, dz;
  logic signed [2*D_W-1:0]      px, py, pz;

  // Stage two: squared differences
  logic                         s2_valid;
  logic                         s2_eof;
  logic                         s2_both;
  logic [SQ_W-1:0]              sq_x, sq_y, sq_z;
  logic [PAY_W-1:0]             s2_data;
  logic [SUM_W-1:0]             dist_sq;
  logic                         fg;

  assign cfg_ready = 1'b1;

  // Merge a configuration write into the register values
  always_comb begin
    thr_next = thr;
    wid_next = wid;
    hei_next = hei;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_next = cfg_data[THR_W-1:0];
        REG_WIDTH:     wid_next = cfg_data[DIM_W-1:0];
        REG_HEIGHT:    hei_next = cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame size: empty counts as one point, oversize clamps to the store depth
  assign prod = PROD_W'(wid_next) * PROD_W'(hei_next);
  always_comb begin
    priority if (prod == '0) begin
      points_next = PN_W'(1);
    end else if (prod > STORE_N) begin
      points_next = PN_W'(STORE_N);
    end else begin
      points_next = prod[PN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= THRESHOLD_RESET;
      wid    <= WIDTH_RESET;
      hei    <= HEIGHT_RESET;
      thr_sq <= RESET_THR_SQ;
      points <= RESET_POINTS;
    end else begin
      thr    <= thr_next;
      wid    <= wid_next;
      hei    <= hei_next;
      thr_sq <= THR_SQ_W'(thr_next) * THR_SQ_W'(thr_next);
      points <= points_next;
    end
  end

  // Admit a point only when the queue can take every point still in flight
  assign inflight = 2'(s1_valid) + 2'(s2_valid);
  assign in_ready = (Q_CNT_W'(q_count) + Q_CNT_W'(inflight)) < Q_CNT_W'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  assign pos_inc   = PN_W'(pos) + PN_W'(1);
  assign frame_end = pos_inc >= points;

  // Advance the scan position and close the capture frame
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      captured <= 1'b0;
    end else if (accept) begin
      pos <= frame_end ? '0 : pos_inc[PB-1:0];
      if (frame_end) begin
        captured <= 1'b1;
      end
    end
  end

  // Write background during capture, read it during compare
  always_ff @(posedge clk) begin
    if (accept && !captured) begin
      mem[pos] <= {in_pvalid, in_z, in_y, in_x};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && captured) begin
      rd_data <= mem[pos];
    end
  end

  // Stage one control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmp    <= captured;
      s1_eof    <= captured && frame_end;
      s1_x      <= in_x;
      s1_y      <= in_y;
      s1_z      <= in_z;
      s1_color  <= in_color;
      s1_pvalid <= in_pvalid;
    end
  end

  // Square the coordinate differences
  assign bg_x      = rd_data[COORD_BITS-1:0];
  assign bg_y      = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign bg_z      = rd_data[3*COORD_BITS-1:2*COORD_BITS];
  assign bg_pvalid = rd_data[MEM_W-1];

  assign dx = D_W'(s1_x) - D_W'(bg_x);
  assign dy = D_W'(s1_y) - D_W'(bg_y);
  assign dz = D_W'(s1_z) - D_W'(bg_z);
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_eof  <= s1_eof;
      s2_both <= s1_cmp && s1_pvalid && bg_pvalid;
      sq_x    <= px[SQ_W-1:0];
      sq_y    <= py[SQ_W-1:0];
      sq_z    <= pz[SQ_W-1:0];
      s2_data <= PAY_W'({s1_color, s1_z, s1_y, s1_x});
    end
  end

  // Sum, compare against the squared threshold and hand over to the queue
  assign dist_sq = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  assign fg      = s2_both && (CMP_W'(dist_sq) > CMP_W'(thr_sq));

  assign push          = s2_valid && (fg || s2_eof);
  assign push_ctrl.fg  = fg;
  assign push_ctrl.eof = s2_eof;
  assign push_data     = s2_data;

endmodule

// File: hw/rtl/pcbs_queue.sv
// Short decision queue between the front end and the result sequencer.
`include "point_cloud_background_subtract_unit_macros.svh"

module pcbs_queue #(
  parameter int WIDTH = 3 * 18 + 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  pcbs_pkg::pcbs_ctrl_t         in_ctrl,
  input  logic [WIDTH-1:0]             in_data,
  input  logic                         pop,
  output logic                         out_valid,
  output pcbs_pkg::pcbs_ctrl_t         out_ctrl,
  output logic [WIDTH-1:0]             out_data,
  output logic [pcbs_pkg::Q_CNT_W-1:0] count
);
  import pcbs_pkg::*;

  pcbs_ctrl_t       ctrl_q [0:QUEUE_DEPTH-1];
  logic [WIDTH-1:0] data_q [0:QUEUE_DEPTH-1];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;

  // Store an entry at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_q[wr_ptr] <= in_ctrl;
      data_q[wr_ptr] <= in_data;
    end
  end

  // Move pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  assign out_valid = count != '0;
  assign out_ctrl  = ctrl_q[rd_ptr];
  assign out_data  = data_q[rd_ptr];

  `PCBS_ASSERT_ALWAYS(a_no_overflow, !(push && !pop && count == Q_CNT_W'(QUEUE_DEPTH)))
  `PCBS_ASSERT_IMPL(a_no_underflow, pop, count != '0)
  `PCBS_ASSERT_NEXT(a_count_grows, push && !pop, count == $past(count) + Q_CNT_W'(1))

endmodule

// File: hw/rtl/pcbs_back.sv
// Back end: turns queued decisions into point and end-of-frame beats.
`include "point_cloud_background_subtract_unit_macros.svh"

module pcbs_back #(
  parameter int PAY_W   = 3 * 18 + 24,
  parameter int TDATA_W = 80
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  pcbs_pkg::pcbs_ctrl_t q_ctrl,
  input  logic [PAY_W-1:0]     q_data,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TDATA_W-1:0]   m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);
  import pcbs_pkg::*;

  logic phase;       // point beat already sent, marker beat still owed
  logic load;
  logic beat_point;

  // Load a new beat whenever the output register is empty or being drained
  assign load       = q_valid && (!m_tvalid || m_tready);
  assign beat_point = q_ctrl.fg && !phase;
  assign q_pop      = load && !(beat_point && q_ctrl.eof);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        phase    <= beat_point && q_ctrl.eof;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Point beat carries the point, marker beat carries zeros and closes the run
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= beat_point ? TDATA_W'(q_data) : '0;
      m_tuser <= beat_point ? KIND_POINT : KIND_EOF;
      m_tlast <= beat_point ? !q_ctrl.eof : 1'b1;
    end
  end

  `PCBS_ASSERT_IMPL(a_phase_pending, phase, q_valid && q_ctrl.fg && q_ctrl.eof)
  `PCBS_ASSERT_IMPL(a_marker_last, m_tvalid && m_tuser == KIND_EOF, m_tlast)
  `PCBS_ASSERT_IMPL(a_marker_zero, m_tvalid && m_tuser == KIND_EOF, m_tdata == '0)

endmodule

// File: test/testbench.sv
// Self-checking testbench for the point cloud background subtraction unit.
`timescale 1ns / 1ps

module testbench;
  import pcbs_pkg::*;

  localparam int POINT_STORE_DEPTH = 262144;
  localparam int COORD_W           = 18;
  localparam int BEAT_DATA_W       = ((3 * COORD_W + COLOR_W + 7) / 8) * 8;
  localparam int CAPTURE_W         = 8;
  localparam int CAPTURE_H         = 6;
  localparam int HOLD_CYCLES       = 200;
  localparam int QUIET_LIMIT       = 4000;
  localparam int SETTLE_CYCLES     = 8;
  localparam int RANDOM_PHASES     = 9;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 18'sh1FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 18'sh20000;

  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;

  typedef struct packed {
    logic                      valid;
    logic [COLOR_W-1:0]        color;
    logic signed [COORD_W-1:0] z, y, x;
  } point_t;

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] z, y, x;
  } bg_point_t;

  typedef struct packed {
    logic                      kind;
    logic                      last;
    logic [COLOR_W-1:0]        color;
    logic signed [COORD_W-1:0] z, y, x;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [BEAT_DATA_W-1:0] s_tdata  = '0;   // point_x, point_y, point_z, point_color
  logic                   s_tuser  = 1'b0; // point_valid

  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [BEAT_DATA_W-1:0] m_tdata;         // out_x, out_y, out_z, out_color
  logic                   m_tuser;         // item_kind
  logic                   m_tlast;         // last_of_run

  // Mirror of the block's registers and state
  logic [THR_W-1:0] cur_thr = THRESHOLD_RESET;
  logic [DIM_W-1:0] cur_w   = WIDTH_RESET;
  logic [DIM_W-1:0] cur_h   = HEIGHT_RESET;
  bg_point_t        bg_store [int];
  int               scan_pos = 0;
  bit               bg_done  = 1'b0;

  point_t     points_pending [$];
  beat_t      results_due [$];
  point_t     offered;
  int         plan_pos = 0;
  idle_mode_t tx_mode = IDLE_FULL;
  idle_mode_t rx_mode = IDLE_FULL;
  int         tx_gap = 0;
  int         rx_wait = 0;
  logic       rx_hold = 1'b0;
  int         quiet_cycles = 0;

  int mismatches = 0;
  int pts_queued = 0;
  int pts_sent   = 0;
  int fg_beats   = 0;
  int eof_beats  = 0;
  int cfg_writes = 0;

  point_cloud_background_subtract_unit #(
    .STORE_POINTS(POINT_STORE_DEPTH),
    .COORD_BITS  (COORD_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Points per frame: zero counts as one, clamp to the store depth
  function automatic int frame_len(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    longint n;
    n = longint'(w) * longint'(h);
    if (n == 0) n = 1;
    if (n > POINT_STORE_DEPTH) n = POINT_STORE_DEPTH;
    return int'(n);
  endfunction

  function automatic int draw_gap(idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 15);
      default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    endcase
  endfunction

  // Expected beats for one accepted point; capture while no background is held
  task automatic predict_foreground(point_t p);
    bg_point_t b;
    beat_t     r;
    int        pos;
    bit        eof;
    longint    dx, dy, dz, d2, t2;
    pos = scan_pos % POINT_STORE_DEPTH;
    eof = (pos + 1 >= frame_len(cur_w, cur_h));
    if (!bg_done) begin
      b.x = p.x;
      b.y = p.y;
      b.z = p.z;
      b.valid = p.valid;
      bg_store[pos] = b;
      if (eof) bg_done = 1'b1;
    end else begin
      b = bg_store.exists(pos) ? bg_store[pos] : '0;
      if (p.valid && b.valid) begin
        dx = longint'(p.x) - longint'(b.x);
        dy = longint'(p.y) - longint'(b.y);
        dz = longint'(p.z) - longint'(b.z);
        d2 = dx * dx + dy * dy + dz * dz;
        t2 = longint'(cur_thr) * longint'(cur_thr);
        if (d2 > t2) begin
          r.kind  = KIND_POINT;
          r.last  = !eof;
          r.color = p.color;
          r.x = p.x;
          r.y = p.y;
          r.z = p.z;
          results_due = {results_due, r};
        end
      end
      if (eof) begin
        r = '0;
        r.kind = KIND_EOF;
        r.last = 1'b1;
        results_due = {results_due, r};
      end
    end
    scan_pos = eof ? 0 : pos + 1;
  endtask

  task automatic note_mismatch(string what, beat_t want, beat_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected kind=%0b x=%0d y=%0d z=%0d color=%06h last=%0b",
               what, want.kind, want.x, want.y, want.z, want.color, want.last);
      $display("%s: got      kind=%0b x=%0d y=%0d z=%0d color=%06h last=%0b",
               what, got.kind, got.x, got.y, got.z, got.color, got.last);
    end
  endtask

  task automatic check_beat(beat_t got);
    beat_t want;
    if (results_due.size() == 0) begin
      note_mismatch("unexpected beat", '0, got);
    end else begin
      want = results_due.pop_front();
      if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
          got.z !== want.z || got.color !== want.color || got.last !== want.last)
        note_mismatch("beat mismatch", want, got);
    end
    if (got.kind === KIND_EOF) eof_beats++;
    else fg_beats++;
  endtask

  // Offer queued points, with a drawn gap after each one
  always @(posedge clk) begin : drive_points
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_foreground(offered);
        pts_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (points_pending.size() != 0) begin
          offered   = points_pending.pop_front();
          s_tdata  <= {{(BEAT_DATA_W - 3 * COORD_W - COLOR_W){1'b0}},
                       offered.color, offered.z, offered.y, offered.x};
          s_tuser  <= offered.valid;
          s_tvalid <= 1'b1;
          tx_gap   <= draw_gap(tx_mode);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Take result beats, stalling a drawn number of cycles after each
  always @(posedge clk) begin : watch_results
    int    nw;
    beat_t got;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else begin
      nw = (rx_wait != 0) ? rx_wait - 1 : 0;
      if (m_tvalid && m_tready) begin
        got.kind  = m_tuser;
        got.last  = m_tlast;
        got.x     = m_tdata[COORD_W-1:0];
        got.y     = m_tdata[2*COORD_W-1:COORD_W];
        got.z     = m_tdata[3*COORD_W-1:2*COORD_W];
        got.color = m_tdata[3*COORD_W+COLOR_W-1:3*COORD_W];
        check_beat(got);
        nw = draw_gap(rx_mode);
      end
      rx_wait  <= nw;
      m_tready <= (nw == 0) && !rx_hold;
    end
  end

  // Abort when nothing moves on any channel for too long
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until every queued point is taken and every result has come out
  task automatic settle();
    while (pts_sent != pts_queued || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    settle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_THRESHOLD: cur_thr = val;
      REG_WIDTH:     cur_w   = val[DIM_W-1:0];
      REG_HEIGHT:    cur_h   = val[DIM_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(int w, int h);
    write_reg(REG_WIDTH, w[CFG_DATA_W-1:0]);
    write_reg(REG_HEIGHT, h[CFG_DATA_W-1:0]);
  endtask

  // Queue a point and track where it lands in the frame
  task automatic send(point_t p);
    points_pending = {points_pending, p};
    pts_queued++;
    plan_pos = (plan_pos + 1 >= frame_len(cur_w, cur_h)) ? 0 : plan_pos + 1;
  endtask

  function automatic point_t make_point(int x, int y, int z, bit v);
    point_t p;
    p.x = x[COORD_W-1:0];
    p.y = y[COORD_W-1:0];
    p.z = z[COORD_W-1:0];
    p.color = COLOR_W'($urandom);
    p.valid = v;
    return p;
  endfunction

  // Move a coordinate towards zero so it never leaves its range
  function automatic logic signed [COORD_W-1:0] toward_zero(logic signed [COORD_W-1:0] b, int off);
    int v;
    v = (b >= 0) ? int'(b) - off : int'(b) + off;
    return v[COORD_W-1:0];
  endfunction

  // Point near, at or far from the background point at a scan position
  function automatic point_t rand_point(int pos);
    bg_point_t b;
    point_t    p;
    b = bg_store[pos];
    p = make_point(b.x, b.y, b.z, 1'b1);
    case ($urandom_range(0, 9))
      0: begin
        p.valid = 1'b0;
        p.x = COORD_W'($urandom);
        p.y = COORD_W'($urandom);
        p.z = COORD_W'($urandom);
      end
      1: begin
        p.x = COORD_W'($urandom);
        p.y = COORD_W'($urandom);
        p.z = COORD_W'($urandom);
      end
      2: begin
        p.x = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        p.y = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        p.z = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      end
      3: p.x = toward_zero(b.x, cur_thr + $urandom_range(0, 1));
      4, 5: begin
        p.x = toward_zero(b.x, $urandom_range(0, cur_thr / 2));
        p.y = toward_zero(b.y, $urandom_range(0, cur_thr / 2));
        p.z = toward_zero(b.z, $urandom_range(0, cur_thr / 2));
      end
      default: begin
        p.x = toward_zero(b.x, $urandom_range(0, cur_thr / 2));
        if ($urandom_range(0, 1)) p.y = toward_zero(b.y, $urandom_range(cur_thr + 1, 65536));
        else p.z = toward_zero(b.z, $urandom_range(cur_thr + 1, 65536));
      end
    endcase
    return p;
  endfunction

  initial begin : stimulus
    int     thr_list [RANDOM_PHASES];
    int     n_items;
    point_t p;
    thr_list = '{600, 0, 1, 65535, 0, 1000, 30, 600, 250};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Capture a small background frame; threshold stays at its reset value
    set_frame(CAPTURE_W, CAPTURE_H);
    write_reg(REG_SPARE, 16'hFFFF);
    for (int i = 0; i < CAPTURE_W * CAPTURE_H; i++) begin
      case (i)
        0: p = make_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        1: p = make_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        2: p = make_point($urandom, $urandom, $urandom, 1'b0);
        3: p = make_point(0, 0, 0, 1'b1);
        default: begin
          if ($urandom_range(0, 1)) p = make_point($urandom, $urandom, $urandom, 1'b1);
          else p = make_point($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                              $urandom_range(0, 2000) - 1000, 1'b1);
          p.valid = ($urandom_range(0, 7) != 0);
        end
      endcase
      send(p);
    end

    // Largest threshold: opposite corners, invalid either side, exact boundary
    write_reg(REG_THRESHOLD, 16'hFFFF);
    set_frame(2, 2);
    send(make_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
    send(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
    send(make_point(0, 0, 0, 1'b1));
    send(make_point(100000, 100000, 100000, 1'b0));
    send(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
    send(make_point(-65537, COORD_MIN, COORD_MIN, 1'b1));
    send(make_point($urandom, $urandom, $urandom, 1'b1));
    send(make_point(65536, 0, 0, 1'b1));

    // Zero threshold on one-point frames, zero sizes counted as one
    write_reg(REG_THRESHOLD, 16'h0000);
    set_frame(1, 1);
    send(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
    send(make_point(131070, COORD_MAX, COORD_MAX, 1'b1));
    set_frame(0, 5);
    send(make_point(COORD_MAX, COORD_MAX, 0, 1'b1));
    set_frame(7, 0);
    send(make_point(COORD_MAX, 0, 0, 1'b0));

    // Clamped frame, then shrink below the scan position to close it
    write_reg(REG_THRESHOLD, 16'd600);
    set_frame(4096, 4096);
    for (int i = 0; i < 6; i++) send(rand_point(plan_pos));
    set_frame(4, 1);
    send(rand_point(plan_pos));
    set_frame(4096, 1);
    for (int i = 0; i < 3; i++) send(rand_point(plan_pos));
    set_frame(1, 4096);
    for (int i = 0; i < 2; i++) send(rand_point(plan_pos));

    // Random phases over every pairing of sender and receiver idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(REG_THRESHOLD,
                CFG_DATA_W'((ph == 4) ? $urandom_range(0, 65535) : thr_list[ph]));
      set_frame($urandom_range(1, CAPTURE_W), $urandom_range(1, CAPTURE_H));
      tx_mode = idle_mode_t'(ph % 3);
      rx_mode = idle_mode_t'((ph / 3) % 3);
      n_items = $urandom_range(55, 65);
      for (int i = 0; i < n_items; i++) send(rand_point(plan_pos));
    end

    // Hold the receiver off while points keep coming, so the input backs up
    write_reg(REG_THRESHOLD, 16'd0);
    set_frame(2, 1);
    tx_mode = IDLE_NONE;
    rx_mode = IDLE_SPARSE;
    fork
      begin
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 40; i++) send(rand_point(plan_pos));

    settle();
    repeat (16) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0d expected beats never arrived", results_due.size());
      mismatches += results_due.size();
    end
    $display("Sent %0d points through %0d register writes, thresholds 0 to 65535 and",
             pts_sent, cfg_writes);
    $display("frame sizes 1 to clamped; checked %0d foreground and %0d end-of-frame beats",
             fg_beats, eof_beats);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
